// ===== rtl/rac_pkg.sv =====
// Shared types, codes and character helpers for the radix accumulator calculator.
`timescale 1ns / 1ps

package rac_pkg;

  typedef enum logic [3:0] {
    OP_NUM    = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_MOD    = 4'd5,
    OP_CHANGE = 4'd6,
    OP_EQUAL  = 4'd7,
    OP_CLEAR  = 4'd8
  } op_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [5:0] digit;
    logic       number_start;
    logic       number_end;
    logic [5:0] new_radix;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic start;
    logic do_div;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] DEC_BASE    = 6'd10;
  localparam logic [5:0] MAX_DIGIT   = 6'd35;
  localparam logic [6:0] CHAR_ZERO   = 7'h30;
  localparam logic [6:0] CHAR_ALPHA  = 7'h41;

  function automatic logic [6:0] char_of(input logic [5:0] d);
    logic [5:0] c;
    logic [5:0] lt;
    c  = (d > MAX_DIGIT) ? MAX_DIGIT : d;
    lt = c - DEC_BASE;
    if (c < DEC_BASE) begin
      return CHAR_ZERO + {1'b0, c};
    end else begin
      return CHAR_ALPHA + {1'b0, lt};
    end
  endfunction

endpackage

// ===== rtl/radix_accumulator_calculator.sv =====
// Top level of the radix accumulator calculator: command sequencer and result channel.
//
// Input channel in_*: one command transaction per item (digit, operator, radix
// change, equal, clear). in_stall_o is high while a command is being worked on.
// Output channel out_*: one transaction per result character, most significant
// digit first; last_char marks the final character of an EQUAL.
// Handling per item:
//   NUM digit without number end, operators, CHANGE, CLEAR: done when accepted.
//   NUM with number end: loads the accumulator when none is held; otherwise ADD/SUB
//   combine directly, MUL/DIV/MOD run in the shared unit (one bit a cycle), and a
//   zero divisor leaves the accumulator unchanged.
//   EQUAL: radix divisions in the shared unit write the digits to the digit RAM, then
//   each character is read through its read port, waiting while out_stall_i holds the output register.
// Up to DIGIT_DEPTH characters per EQUAL. A stalled character stays in the output
// register; the block then waits before loading the next one. The final character
// may wait there while the next command is accepted.
// Reset: accumulator and operand zero, no accumulator held, pending ADD, radix ten,
// output channel empty. The digit RAM is not cleared.
`timescale 1ns / 1ps

module radix_accumulator_calculator #(
  parameter int VALUE_WIDTH = 64,
  parameter int DIGIT_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  rac_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output rac_pkg::out_t out_data_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(DIGIT_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COMB  = 3'd1;
  localparam logic [2:0] S_CWAIT = 3'd2;
  localparam logic [2:0] S_EDIV  = 3'd3;
  localparam logic [2:0] S_EWAIT = 3'd4;
  localparam logic [2:0] S_RADDR = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  opnd_q, opnd_d;
  logic          have_q, have_d;
  logic [2:0]    pend_q, pend_d;
  logic [5:0]    radix_q, radix_d;
  logic [W-1:0]  v_q, v_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  rac_pkg::out_t out_q, out_d;

  logic                in_acc;
  logic                out_free;
  logic [W-1:0]        opnd_base;
  logic [W+5:0]        mprod;
  logic [W-1:0]        num_val;
  logic [AW:0]         next_cnt;

  rac_pkg::unit_req_t  ureq;
  rac_pkg::unit_rsp_t  ursp;
  logic [W-1:0]        unit_a;
  logic [W-1:0]        unit_b;
  logic [W-1:0]        quo;
  logic [W-1:0]        rem;

  logic                ram_we;
  logic                ram_re;
  logic [5:0]          ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign opnd_base = in_data_i.number_start ? '0 : opnd_q;
  assign mprod     = (W+6)'(opnd_base) * (W+6)'(radix_q);
  assign num_val   = mprod[W-1:0] + {{(W-6){1'b0}}, in_data_i.digit};
  assign next_cnt  = {1'b0, idx_q} + (AW+1)'(1);

  assign unit_a = (state_q == S_COMB) ? acc_q : v_q;
  assign unit_b = (state_q == S_COMB) ? opnd_q : {{(W-6){1'b0}}, radix_q};

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    have_d      = have_q;
    pend_d      = pend_q;
    radix_d     = radix_q;
    v_d         = v_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ureq.start  = 1'b0;
    ureq.do_div = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            rac_pkg::OP_NUM: begin
              opnd_d = num_val;
              if (in_data_i.number_end) begin
                if (!have_q) begin
                  acc_d  = num_val;
                  have_d = 1'b1;
                end else begin
                  state_d = S_COMB;
                end
              end
            end
            rac_pkg::OP_ADD, rac_pkg::OP_SUB, rac_pkg::OP_MUL,
            rac_pkg::OP_DIV, rac_pkg::OP_MOD: begin
              pend_d = in_data_i.opcode[2:0];
            end
            rac_pkg::OP_CHANGE: begin
              if (in_data_i.new_radix >= rac_pkg::RADIX_MIN &&
                  in_data_i.new_radix <= rac_pkg::RADIX_MAX) begin
                radix_d = in_data_i.new_radix;
              end
            end
            rac_pkg::OP_EQUAL: begin
              v_d     = acc_q;
              idx_d   = '0;
              state_d = S_EDIV;
            end
            rac_pkg::OP_CLEAR: begin
              have_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_COMB: begin
        state_d = S_IDLE;
        case (pend_q)
          3'(rac_pkg::OP_ADD): acc_d = acc_q + opnd_q;
          3'(rac_pkg::OP_SUB): acc_d = acc_q - opnd_q;
          3'(rac_pkg::OP_MUL): begin
            ureq.start  = 1'b1;
            ureq.do_div = 1'b0;
            state_d     = S_CWAIT;
          end
          3'(rac_pkg::OP_DIV), 3'(rac_pkg::OP_MOD): begin
            if (opnd_q != '0) begin
              ureq.start = 1'b1;
              state_d    = S_CWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_CWAIT: begin
        if (ursp.done) begin
          state_d = S_IDLE;
          case (pend_q)
            3'(rac_pkg::OP_MUL): acc_d = rem;
            3'(rac_pkg::OP_DIV): acc_d = quo;
            3'(rac_pkg::OP_MOD): acc_d = rem;
            default: begin
            end
          endcase
        end
      end
      S_EDIV: begin
        ureq.start = 1'b1;
        state_d    = S_EWAIT;
      end
      S_EWAIT: begin
        if (ursp.done) begin
          ram_we = 1'b1;
          v_d    = quo;
          if (quo != '0 && next_cnt < (AW+1)'(DIGIT_DEPTH)) begin
            idx_d   = next_cnt[AW-1:0];
            state_d = S_EDIV;
          end else begin
            state_d = S_RADDR;
          end
        end
      end
      S_RADDR: begin
        ram_re  = 1'b1;
        state_d = S_RDATA;
      end
      S_RDATA: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.char_code = rac_pkg::char_of(ram_rdata);
          out_d.last_char = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_RADDR;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      opnd_q      <= '0;
      have_q      <= 1'b0;
      pend_q      <= 3'(rac_pkg::OP_ADD);
      radix_q     <= rac_pkg::RADIX_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      opnd_q      <= opnd_d;
      have_q      <= have_d;
      pend_q      <= pend_d;
      radix_q     <= radix_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    out_q <= out_d;
  end

  rac_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .rsp_o  (ursp),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  rac_ram #(
    .WIDTH(6),
    .DEPTH(DIGIT_DEPTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (rem[5:0]),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/rac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rac_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rac_unit.sv =====
// Shared bit-serial multiply and divide unit, one bit per cycle.
`timescale 1ns / 1ps

module rac_unit #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rac_pkg::unit_req_t     req_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output rac_pkg::unit_rsp_t     rsp_o,
  output logic [VALUE_WIDTH-1:0] quo_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  r_q, r_d;

  logic [W:0]    opa;
  logic [W:0]    opb;
  logic [W+1:0]  res;
  logic          ge;

  always_comb begin
    if (div_q) begin
      opa = {r_q, a_q[W-1]};
      opb = {1'b0, b_q};
      res = {1'b0, opa} - {1'b0, opb};
    end else begin
      opa = {1'b0, r_q[W-2:0], 1'b0};
      opb = a_q[W-1] ? {1'b0, b_q} : '0;
      res = {1'b0, opa} + {1'b0, opb};
    end
    ge = ~res[W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.do_div;
      cnt_d  = CW'(W);
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      a_d   = {a_q[W-2:0], div_q & ge};
      cnt_d = cnt_q - CW'(1);
      if (div_q) begin
        r_d = ge ? res[W-1:0] : opa[W-1:0];
      end else begin
        r_d = res[W-1:0];
      end
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign quo_o      = a_q;
  assign rem_o      = r_q;

endmodule

// ===== rtl/rac_checker.sv =====
// Port-level assertions for the radix accumulator calculator, bound to the top level.
`timescale 1ns / 1ps

module rac_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input rac_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rac_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_equal_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.opcode == rac_pkg::OP_EQUAL |=> in_stall_o)
    else $error("equal transaction did not occupy the block");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> out_data_o.last_char)
    else $error("block idle with an unfinished result pending");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.char_code >= 7'h30 && out_data_o.char_code <= 7'h39) ||
                    (out_data_o.char_code >= 7'h41 && out_data_o.char_code <= 7'h5A))
    else $error("result character outside 0-9 and A-Z");

endmodule

bind radix_accumulator_calculator rac_checker u_rac_checker (.*);
